>>> hw/rtl/bfa_pkg.sv
// bfa_pkg: shared types, codes and constants of the best-fit allocator
// depends on nothing; imported by every allocator module
package bfa_pkg;

	// fixed field widths
	localparam int unsigned KIB_W      = 11;
	localparam int unsigned REQ_ID_W   = 10;
	localparam int unsigned REQ_SIZE_W = 21;
	localparam int unsigned STATUS_W   = 3;

	// managed size limits
	localparam int unsigned KIB_MAX   = 1024;
	localparam int unsigned KIB_SHIFT = 10;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED  = 3'd0,
		ST_NOFIT    = 3'd1,
		ST_FREED    = 3'd2,
		ST_NOTALLOC = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		G_NONE  = 2'd0,
		G_ALLOC = 2'd1,
		G_DONE  = 2'd2
	} grant_st_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_GCHK,
		S_SCAN,
		S_DECIDE,
		S_RESULT
	} fsm_t;

	// valid-bit operation on the segment table
	typedef struct packed {
		logic init;
		logic set;
		logic clr;
	} seg_vld_op_t;

	// managed size in bytes: clamp kib to 1..1024, cap at 2^abits
	function automatic logic [32:0] mem_bytes(logic [KIB_W-1:0] kib, int unsigned abits);
		logic [32:0] k;
		logic [32:0] b;
		logic [32:0] lim;
		k = {22'd0, kib};
		if (k == 33'd0) k = 33'd1;
		if (k > 33'(KIB_MAX)) k = 33'(KIB_MAX);
		b = k << KIB_SHIFT;
		lim = 33'd1 << abits;
		if (b > lim) b = lim;
		return b;
	endfunction

endpackage

>>> hw/rtl/best_fit_allocator.sv
// best_fit_allocator: best-fit allocator with coalescing free segment table
// allocate and free requests scan the whole segment table, one entry per cycle, before deciding;
// zero-size allocates and bad ids go straight to the result, unknown frees after the grant check
// throughput: one request at a time; the next request is taken once the result is registered
// reset and every cfg_data write run a clearing pass over all REQUEST_SLOTS
// grant records, during which no request is accepted
module best_fit_allocator import bfa_pkg::*; #(
	parameter int unsigned REQUEST_SLOTS = 1024,
	parameter int unsigned MAX_SEGMENTS  = 64,
	parameter int unsigned ADDR_BITS     = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [REQ_ID_W-1:0]                req_id,
	input  logic [REQ_SIZE_W-1:0]              req_size,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [STATUS_W-1:0]                status,
	output logic [ADDR_BITS-1:0]               base_addr,
	output logic [ADDR_BITS:0]                 bytes_left,
	output logic [$clog2(MAX_SEGMENTS+1)-1:0]  free_segments,
	output logic [ADDR_BITS:0]                 largest_free,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [KIB_W-1:0]                   cfg_data
);

	localparam int unsigned SW   = ADDR_BITS + 1;
	localparam int unsigned EW   = ADDR_BITS + 2;
	localparam int unsigned CW   = (SW > REQ_SIZE_W) ? SW : REQ_SIZE_W;
	localparam int unsigned SIW  = $clog2(MAX_SEGMENTS);
	localparam int unsigned CNTW = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned GIW  = $clog2(REQUEST_SLOTS);

	fsm_t state_q, state_d;

	// request registers
	cmd_t                  cmd_q;
	logic [REQ_ID_W-1:0]   id_q;
	logic [REQ_SIZE_W-1:0] size_q;
	logic                  id_ok;
	logic [GIW-1:0]        slot_idx;
	logic [SW-1:0]         req_sw;

	// global statistics
	logic [SW-1:0]   bytes_q;
	logic [SW-1:0]   total_q;
	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   largest_q;

	// clearing pass and scan counters
	logic [GIW-1:0]  clr_q;
	logic [CNTW-1:0] scan_q;
	logic            rd_s1;
	logic [SIW-1:0]  idx_s1;

	// scan trackers
	logic                 pick_found_q;
	logic [SIW-1:0]       pick_ix_q;
	logic [SW-1:0]        pick_sz_q;
	logic [ADDR_BITS-1:0] pick_base_q;
	logic                 t_ok_q [3];
	logic [SW-1:0]        t_sz_q [3];
	logic [SIW-1:0]       t_ix_q [3];
	logic                 left_found_q, right_found_q, slot_found_q;
	logic [SIW-1:0]       left_ix_q, right_ix_q, slot_ix_q;
	logic [SW-1:0]        left_sz_q, right_sz_q;
	logic [ADDR_BITS-1:0] fb_q;
	logic [SW-1:0]        fs_q;

	// result registers
	status_t              res_status_q;
	logic [ADDR_BITS-1:0] res_base_q;
	status_t              out_status_q;
	logic [ADDR_BITS-1:0] out_base_q;
	logic [SW-1:0]        out_bytes_q;
	logic [CNTW-1:0]      out_cnt_q;
	logic [SW-1:0]        out_large_q;
	logic                 out_valid_q;

	// memory interfaces
	logic                 seg_rd_en;
	logic [SIW-1:0]       seg_rd_addr;
	logic [ADDR_BITS-1:0] seg_rd_base;
	logic [SW-1:0]        seg_rd_size;
	logic                 seg_rd_valid;
	logic                 seg_wr_en;
	logic [SIW-1:0]       seg_wr_addr;
	logic [ADDR_BITS-1:0] seg_wr_base;
	logic [SW-1:0]        seg_wr_size;
	seg_vld_op_t          vld_op;
	logic [SIW-1:0]       vld_addr;
	logic                 g_rd_en;
	logic [ADDR_BITS-1:0] g_rd_base;
	logic [SW-1:0]        g_rd_size;
	grant_st_t            g_rd_status;
	logic                 g_wr_en;
	logic [GIW-1:0]       g_wr_addr;
	logic [ADDR_BITS-1:0] g_wr_base;
	logic [SW-1:0]        g_wr_size;
	grant_st_t            g_wr_status;

	// decide outputs
	status_t              d_status;
	logic [ADDR_BITS-1:0] d_base;
	logic [SW-1:0]        d_total;
	logic [CNTW-1:0]      d_cnt;
	logic [SW-1:0]        d_largest;
	logic [SW-1:0]        ex_large;
	logic                 ex_hit;

	// scan evaluation
	logic          eval_ok;
	logic          ins0, ins1, ins2;
	logic [EW-1:0] seg_end, fb_end;
	logic          cfg_acc, in_acc, load_out;
	logic [SW-1:0] cfg_bytes;

	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_acc    = in_valid & in_ready;
	assign load_out  = (state_q == S_RESULT) && (!out_valid_q || out_ready);
	assign cfg_bytes = SW'(mem_bytes(cfg_data, ADDR_BITS));
	assign id_ok     = 32'(id_q) < 32'(REQUEST_SLOTS);
	assign slot_idx  = GIW'(id_q);
	assign req_sw    = SW'(size_q);

	bfa_seg_store #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS),
		.SIW          (SIW),
		.SW           (SW)
	) u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (seg_rd_en),
		.rd_addr  (seg_rd_addr),
		.rd_base  (seg_rd_base),
		.rd_size  (seg_rd_size),
		.rd_valid (seg_rd_valid),
		.wr_en    (seg_wr_en),
		.wr_addr  (seg_wr_addr),
		.wr_base  (seg_wr_base),
		.wr_size  (seg_wr_size),
		.vld_op   (vld_op),
		.vld_addr (vld_addr)
	);

	bfa_grant_store #(
		.REQUEST_SLOTS (REQUEST_SLOTS),
		.ADDR_BITS     (ADDR_BITS),
		.GIW           (GIW),
		.SW            (SW)
	) u_grant (
		.clk       (clk),
		.rd_en     (g_rd_en),
		.rd_addr   (slot_idx),
		.rd_base   (g_rd_base),
		.rd_size   (g_rd_size),
		.rd_status (g_rd_status),
		.wr_en     (g_wr_en),
		.wr_addr   (g_wr_addr),
		.wr_base   (g_wr_base),
		.wr_size   (g_wr_size),
		.wr_status (g_wr_status)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (!cfg_acc && clr_q == GIW'(REQUEST_SLOTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_acc) state_d = S_CLEAR;
				else if (in_acc) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (!id_ok || (cmd_q == CMD_ALLOC && size_q == '0)) state_d = S_RESULT;
				else if (cmd_q == CMD_ALLOC) state_d = S_SCAN;
				else state_d = S_GCHK;
			end
			S_GCHK: begin
				if (g_rd_status != G_ALLOC) state_d = S_RESULT;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_q == CNTW'(MAX_SEGMENTS)) state_d = S_DECIDE;
			end
			S_DECIDE: state_d = S_RESULT;
			S_RESULT: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// handshake and memory read controls
	always_comb begin
		in_ready    = (state_q == S_IDLE) && !cfg_valid;
		cfg_ready   = (state_q == S_IDLE) || (state_q == S_CLEAR);
		seg_rd_en   = (state_q == S_SCAN) && (scan_q != CNTW'(MAX_SEGMENTS));
		seg_rd_addr = SIW'(scan_q);
		g_rd_en     = (state_q == S_LOOKUP);
	end

	// scan evaluation of the entry read last cycle
	always_comb begin
		eval_ok = (state_q == S_SCAN) && rd_s1 && seg_rd_valid;
		ins0 = eval_ok && (!t_ok_q[0] || seg_rd_size > t_sz_q[0]);
		ins1 = eval_ok && !ins0 && (!t_ok_q[1] || seg_rd_size > t_sz_q[1]);
		ins2 = eval_ok && !ins0 && !ins1 && (!t_ok_q[2] || seg_rd_size > t_sz_q[2]);
		seg_end = EW'(seg_rd_base) + EW'(seg_rd_size);
		fb_end  = EW'(fb_q) + EW'(fs_q);
	end

	// largest segment among the ones this request leaves untouched
	always_comb begin
		ex_large = '0;
		ex_hit   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (!ex_hit && t_ok_q[i]) begin
				if (cmd_q == CMD_ALLOC) begin
					if (!(pick_found_q && t_ix_q[i] == pick_ix_q)) begin
						ex_large = t_sz_q[i];
						ex_hit   = 1'b1;
					end
				end else if (!((left_found_q && t_ix_q[i] == left_ix_q) ||
				               (right_found_q && t_ix_q[i] == right_ix_q))) begin
					ex_large = t_sz_q[i];
					ex_hit   = 1'b1;
				end
			end
		end
	end

	// update decision, memory writes
	always_comb begin
		logic [SW-1:0] new_sz;
		new_sz      = '0;
		d_status    = ST_NOFIT;
		d_base      = '0;
		d_total     = total_q;
		d_cnt       = cnt_q;
		d_largest   = largest_q;
		seg_wr_en   = 1'b0;
		seg_wr_addr = pick_ix_q;
		seg_wr_base = pick_base_q + ADDR_BITS'(size_q);
		seg_wr_size = '0;
		vld_op      = '0;
		vld_addr    = pick_ix_q;
		g_wr_en     = 1'b0;
		g_wr_addr   = slot_idx;
		g_wr_base   = pick_base_q;
		g_wr_size   = req_sw;
		g_wr_status = G_ALLOC;
		if (state_q == S_CLEAR) begin
			g_wr_en     = 1'b1;
			g_wr_addr   = clr_q;
			g_wr_status = G_NONE;
			seg_wr_en   = (clr_q == '0);
			seg_wr_addr = '0;
			seg_wr_base = '0;
			seg_wr_size = bytes_q;
		end else if (state_q == S_DECIDE) begin
			if (cmd_q == CMD_ALLOC) begin
				if (pick_found_q) begin
					new_sz    = pick_sz_q - req_sw;
					d_status  = ST_GRANTED;
					d_base    = pick_base_q;
					d_total   = total_q - req_sw;
					d_largest = (new_sz > ex_large) ? new_sz : ex_large;
					g_wr_en   = 1'b1;
					if (new_sz == '0) begin
						vld_op.clr = 1'b1;
						d_cnt      = cnt_q - CNTW'(1);
					end else begin
						seg_wr_en   = 1'b1;
						seg_wr_size = new_sz;
					end
				end
			end else begin
				g_wr_base   = fb_q;
				g_wr_size   = fs_q;
				g_wr_status = G_DONE;
				if (left_found_q && right_found_q) begin
					new_sz      = left_sz_q + fs_q + right_sz_q;
					seg_wr_en   = 1'b1;
					seg_wr_addr = left_ix_q;
					seg_wr_base = fb_q - ADDR_BITS'(left_sz_q);
					vld_op.clr  = 1'b1;
					vld_addr    = right_ix_q;
					d_cnt       = cnt_q - CNTW'(1);
				end else if (left_found_q) begin
					new_sz      = left_sz_q + fs_q;
					seg_wr_en   = 1'b1;
					seg_wr_addr = left_ix_q;
					seg_wr_base = fb_q - ADDR_BITS'(left_sz_q);
				end else if (right_found_q) begin
					new_sz      = right_sz_q + fs_q;
					seg_wr_en   = 1'b1;
					seg_wr_addr = right_ix_q;
					seg_wr_base = fb_q;
				end else if (slot_found_q) begin
					new_sz      = fs_q;
					seg_wr_en   = 1'b1;
					seg_wr_addr = slot_ix_q;
					seg_wr_base = fb_q;
					vld_op.set  = 1'b1;
					vld_addr    = slot_ix_q;
					d_cnt       = cnt_q + CNTW'(1);
				end
				seg_wr_size = new_sz;
				if (left_found_q || right_found_q || slot_found_q) begin
					d_status  = ST_FREED;
					d_base    = fb_q;
					d_total   = total_q + fs_q;
					d_largest = (new_sz > ex_large) ? new_sz : ex_large;
					g_wr_en   = 1'b1;
				end else begin
					d_status = ST_FULL;
				end
			end
		end
		if (cfg_acc) begin
			vld_op.init = 1'b1;
		end
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			rd_s1       <= 1'b0;
			bytes_q     <= SW'(mem_bytes(KIB_W'(KIB_MAX), ADDR_BITS));
			total_q     <= SW'(mem_bytes(KIB_W'(KIB_MAX), ADDR_BITS));
			largest_q   <= SW'(mem_bytes(KIB_W'(KIB_MAX), ADDR_BITS));
			cnt_q       <= CNTW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// clearing pass
			if (cfg_acc) begin
				clr_q     <= '0;
				bytes_q   <= cfg_bytes;
				total_q   <= cfg_bytes;
				largest_q <= cfg_bytes;
				cnt_q     <= CNTW'(1);
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + GIW'(1);
			end
			// scan counter and read pipeline flag
			if (state_q == S_SCAN) begin
				scan_q <= scan_q + CNTW'(1);
			end else begin
				scan_q <= '0;
			end
			rd_s1 <= seg_rd_en;
			// statistics after the update
			if (state_q == S_DECIDE) begin
				total_q   <= d_total;
				cnt_q     <= d_cnt;
				largest_q <= d_largest;
			end
			// result handoff
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, trackers and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= cmd_t'(cmd);
			id_q   <= req_id;
			size_q <= req_size;
		end
		idx_s1 <= seg_rd_addr;
		// tracker init before a scan
		if (state_q == S_LOOKUP || state_q == S_GCHK) begin
			pick_found_q  <= 1'b0;
			left_found_q  <= 1'b0;
			right_found_q <= 1'b0;
			slot_found_q  <= 1'b0;
			for (int i = 0; i < 3; i++) t_ok_q[i] <= 1'b0;
		end
		if (state_q == S_GCHK) begin
			fb_q <= g_rd_base;
			fs_q <= g_rd_size;
		end
		// largest three segments
		if (ins0) begin
			t_ok_q[2] <= t_ok_q[1]; t_sz_q[2] <= t_sz_q[1]; t_ix_q[2] <= t_ix_q[1];
			t_ok_q[1] <= t_ok_q[0]; t_sz_q[1] <= t_sz_q[0]; t_ix_q[1] <= t_ix_q[0];
			t_ok_q[0] <= 1'b1;      t_sz_q[0] <= seg_rd_size; t_ix_q[0] <= idx_s1;
		end else if (ins1) begin
			t_ok_q[2] <= t_ok_q[1]; t_sz_q[2] <= t_sz_q[1]; t_ix_q[2] <= t_ix_q[1];
			t_ok_q[1] <= 1'b1;      t_sz_q[1] <= seg_rd_size; t_ix_q[1] <= idx_s1;
		end else if (ins2) begin
			t_ok_q[2] <= 1'b1;      t_sz_q[2] <= seg_rd_size; t_ix_q[2] <= idx_s1;
		end
		// best fit, ties to lowest base
		if (eval_ok && cmd_q == CMD_ALLOC && CW'(seg_rd_size) >= CW'(size_q)) begin
			if (!pick_found_q || seg_rd_size < pick_sz_q ||
			    (seg_rd_size == pick_sz_q && seg_rd_base < pick_base_q)) begin
				pick_found_q <= 1'b1;
				pick_ix_q    <= idx_s1;
				pick_sz_q    <= seg_rd_size;
				pick_base_q  <= seg_rd_base;
			end
		end
		// free neighbors and first empty entry
		if (state_q == S_SCAN && rd_s1 && cmd_q == CMD_FREE) begin
			if (!seg_rd_valid) begin
				if (!slot_found_q) begin
					slot_found_q <= 1'b1;
					slot_ix_q    <= idx_s1;
				end
			end else begin
				if (seg_end == EW'(fb_q) && !left_found_q) begin
					left_found_q <= 1'b1;
					left_ix_q    <= idx_s1;
					left_sz_q    <= seg_rd_size;
				end
				if (EW'(seg_rd_base) == fb_end && !right_found_q) begin
					right_found_q <= 1'b1;
					right_ix_q    <= idx_s1;
					right_sz_q    <= seg_rd_size;
				end
			end
		end
		// result of the request
		if (state_q == S_LOOKUP) begin
			res_status_q <= (cmd_q == CMD_ALLOC) ? ST_NOFIT : ST_NOTALLOC;
			res_base_q   <= '0;
		end else if (state_q == S_GCHK) begin
			res_status_q <= ST_NOTALLOC;
			res_base_q   <= '0;
		end else if (state_q == S_DECIDE) begin
			res_status_q <= d_status;
			res_base_q   <= d_base;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_base_q   <= res_base_q;
			out_bytes_q  <= total_q;
			out_cnt_q    <= cnt_q;
			out_large_q  <= largest_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign base_addr     = out_base_q;
	assign bytes_left    = out_bytes_q;
	assign free_segments = out_cnt_q;
	assign largest_free  = out_large_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_SEGMENTS))
		else $error("segment count above table depth");
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= bytes_q)
		else $error("free total above managed size");
	a_largest_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == (largest_q == '0))
		else $error("largest segment disagrees with segment count");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result raised outside result state");
`endif

endmodule

>>> hw/rtl/bfa_seg_store.sv
// bfa_seg_store: free segment table memory (base, size) with valid flops
// depends on bfa_pkg
module bfa_seg_store import bfa_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = 64,
	parameter int unsigned ADDR_BITS    = 20,
	parameter int unsigned SIW          = $clog2(MAX_SEGMENTS),
	parameter int unsigned SW           = ADDR_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [SIW-1:0]       rd_addr,
	output logic [ADDR_BITS-1:0] rd_base,
	output logic [SW-1:0]        rd_size,
	output logic                 rd_valid,
	input  logic                 wr_en,
	input  logic [SIW-1:0]       wr_addr,
	input  logic [ADDR_BITS-1:0] wr_base,
	input  logic [SW-1:0]        wr_size,
	input  seg_vld_op_t          vld_op,
	input  logic [SIW-1:0]       vld_addr
);

	logic [ADDR_BITS-1:0] base_mem [MAX_SEGMENTS];
	logic [SW-1:0]        size_mem [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] valid_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[wr_addr] <= wr_base;
			size_mem[wr_addr] <= wr_size;
		end
		if (rd_en) begin
			rd_base <= base_mem[rd_addr];
			rd_size <= size_mem[rd_addr];
		end
	end

	// valid bits, only entry 0 valid after reset or rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= MAX_SEGMENTS'(1);
			rd_valid <= 1'b0;
		end else begin
			if (vld_op.init) begin
				valid_q <= MAX_SEGMENTS'(1);
			end else if (vld_op.set) begin
				valid_q[vld_addr] <= 1'b1;
			end else if (vld_op.clr) begin
				valid_q[vld_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid <= valid_q[rd_addr];
			end
		end
	end

endmodule

>>> hw/rtl/bfa_grant_store.sv
// bfa_grant_store: grant record memory (base, size, status) per request slot
// depends on bfa_pkg
module bfa_grant_store import bfa_pkg::*; #(
	parameter int unsigned REQUEST_SLOTS = 1024,
	parameter int unsigned ADDR_BITS     = 20,
	parameter int unsigned GIW           = $clog2(REQUEST_SLOTS),
	parameter int unsigned SW            = ADDR_BITS + 1
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [GIW-1:0]       rd_addr,
	output logic [ADDR_BITS-1:0] rd_base,
	output logic [SW-1:0]        rd_size,
	output grant_st_t            rd_status,
	input  logic                 wr_en,
	input  logic [GIW-1:0]       wr_addr,
	input  logic [ADDR_BITS-1:0] wr_base,
	input  logic [SW-1:0]        wr_size,
	input  grant_st_t            wr_status
);

	logic [ADDR_BITS-1:0] base_mem [REQUEST_SLOTS];
	logic [SW-1:0]        size_mem [REQUEST_SLOTS];
	grant_st_t            stat_mem [REQUEST_SLOTS];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[wr_addr] <= wr_base;
			size_mem[wr_addr] <= wr_size;
			stat_mem[wr_addr] <= wr_status;
		end
		if (rd_en) begin
			rd_base   <= base_mem[rd_addr];
			rd_size   <= size_mem[rd_addr];
			rd_status <= stat_mem[rd_addr];
		end
	end

endmodule
